// ----- rtl/chgs_pkg.sv -----
package chgs_pkg;

   localparam int MAX_POINTS = 64;
   localparam int COORD_W    = 16;
   localparam int TOL_W      = 16;
   localparam int IDX_W      = $clog2(MAX_POINTS);
   localparam int CNT_W      = $clog2(MAX_POINTS + 1);
   localparam int DIFF_W     = COORD_W + 1;
   localparam int PROD_W     = 2 * DIFF_W;
   localparam int CROSS_W    = PROD_W + 1;

   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
   } point_type;

   typedef enum logic [1:0] {
      TURN_COL,
      TURN_CW,
      TURN_CCW
   } turn_type;

   typedef struct packed {
      logic     valid;
      turn_type code;
      logic     nearer;   // |q - p| < |r - p|
   } geo_res_type;

   typedef enum logic [4:0] {
      ST_LOAD,
      ST_SWAP_RD,
      ST_SWAP_WR,
      ST_SWAP_PIV,
      ST_SORT_I,
      ST_SORT_TMP,
      ST_SORT_K,
      ST_SORT_GO,
      ST_SORT_WAIT,
      ST_DD_I,
      ST_DD_A,
      ST_DD_J,
      ST_DD_GO,
      ST_DD_WAIT,
      ST_CHECK,
      ST_SC_INIT0,
      ST_SC_INIT1,
      ST_SC_INIT2,
      ST_SC_I,
      ST_SC_C,
      ST_SC_TEST,
      ST_SC_WAIT,
      ST_SC_POP1,
      ST_SC_POP2,
      ST_EM_RD,
      ST_EM_PT,
      ST_EM_OUT
   } state_type;

endpackage

// ----- rtl/chgs_geom.sv -----
module chgs_geom (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  chgs_pkg::point_type  p,
   input  chgs_pkg::point_type  q,
   input  chgs_pkg::point_type  r,
   input  logic [chgs_pkg::TOL_W-1:0] tol,
   output chgs_pkg::geo_res_type res
);
   import chgs_pkg::*;

   // stage 1: differences
   logic                     v1_ff;
   logic signed [DIFF_W-1:0] d1_ff, d2_ff, d3_ff, d4_ff, e1_ff, e2_ff;
   // stage 2: products
   logic                     v2_ff;
   logic signed [PROD_W-1:0] p12_ff, p34_ff, sq1_ff, sq3_ff, se1_ff, se2_ff;
   // stage 3: cross product and squared distances
   logic                      v3_ff;
   logic signed [CROSS_W-1:0] cross_ff, dq_ff, dr_ff;
   logic        [CROSS_W-1:0] cross_mag;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= start;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      d1_ff <= DIFF_W'(q.y) - DIFF_W'(p.y);
      d2_ff <= DIFF_W'(r.x) - DIFF_W'(q.x);
      d3_ff <= DIFF_W'(q.x) - DIFF_W'(p.x);
      d4_ff <= DIFF_W'(r.y) - DIFF_W'(q.y);
      e1_ff <= DIFF_W'(r.x) - DIFF_W'(p.x);
      e2_ff <= DIFF_W'(r.y) - DIFF_W'(p.y);

      p12_ff <= d1_ff * d2_ff;
      p34_ff <= d3_ff * d4_ff;
      sq1_ff <= d1_ff * d1_ff;
      sq3_ff <= d3_ff * d3_ff;
      se1_ff <= e1_ff * e1_ff;
      se2_ff <= e2_ff * e2_ff;

      cross_ff <= CROSS_W'(p12_ff) - CROSS_W'(p34_ff);
      dq_ff    <= CROSS_W'(sq1_ff) + CROSS_W'(sq3_ff);
      dr_ff    <= CROSS_W'(se1_ff) + CROSS_W'(se2_ff);
   end

   assign cross_mag = cross_ff[CROSS_W-1] ? CROSS_W'(-cross_ff) : CROSS_W'(cross_ff);

   always_comb begin
      res.valid  = v3_ff;
      res.nearer = dq_ff < dr_ff;
      if (cross_mag <= CROSS_W'(tol)) begin
         res.code = TURN_COL;
      end else if (cross_ff[CROSS_W-1]) begin
         res.code = TURN_CCW;
      end else begin
         res.code = TURN_CW;
      end
   end

endmodule

// ----- rtl/convex_hull_graham_scan_core.sv -----
// channel  dir  handshake            payload
// req      in   req_valid/req_ready  req_point_x, req_point_y, req_last_point
// rsp      out  rsp_valid/rsp_ready  rsp_hull_x, rsp_hull_y, rsp_last_vertex,
//                                    rsp_no_hull, rsp_overflowed
// csr      in   csr_valid/csr_ready  csr_collinear_tolerance
//
// Points load one per cycle into the point RAM; the pivot is tracked while loading.
// After the last point the set is sorted in place (insertion sort, each compare going
// through the 3-stage orientation unit), thinned, then scanned and emitted. req_ready
// is low from the last point until the hull's final beat is in the output register.
// Reset is synchronous; the RAMs need no clearing.
module convex_hull_graham_scan_core (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic signed [chgs_pkg::COORD_W-1:0]  req_point_x,
   input  logic signed [chgs_pkg::COORD_W-1:0]  req_point_y,
   input  logic                                 req_last_point,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [chgs_pkg::COORD_W-1:0]  rsp_hull_x,
   output logic signed [chgs_pkg::COORD_W-1:0]  rsp_hull_y,
   output logic                                 rsp_last_vertex,
   output logic                                 rsp_no_hull,
   output logic                                 rsp_overflowed,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [chgs_pkg::TOL_W-1:0]           csr_collinear_tolerance
);
   import chgs_pkg::*;

   state_type state_ff, state_in;

   logic [CNT_W-1:0] count_ff, count_in;
   logic             ovf_ff, ovf_in;
   logic             ov_ff, ov_in;
   point_type        piv_ff, piv_in;
   logic [IDX_W-1:0] low_ff, low_in;
   logic [CNT_W-1:0] n_ff, n_in, m_ff, m_in, i_ff, i_in, k_ff, k_in, d_ff, d_in;
   point_type        tmp_ff, tmp_in, prev_ff, prev_in, sec_ff, sec_in, top_ff, top_in;
   logic [TOL_W-1:0] tol_ff;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic signed [COORD_W-1:0]  rsp_x_ff, rsp_x_in, rsp_y_ff, rsp_y_in;
   logic                       rsp_last_ff, rsp_last_in, rsp_nohull_ff, rsp_nohull_in;
   logic                       rsp_ov_ff, rsp_ov_in;

   // point RAM and stack RAM
   point_type        pt_mem [MAX_POINTS];
   point_type        pt_rd_ff;
   logic             pm_re, pm_we;
   logic [IDX_W-1:0] pm_raddr, pm_waddr;
   point_type        pm_wdata;

   logic [IDX_W-1:0] stk_mem [MAX_POINTS];
   logic [IDX_W-1:0] stk_rd_ff;
   logic             stk_re, stk_we;
   logic [IDX_W-1:0] stk_raddr, stk_waddr, stk_wdata;

   logic        geo_start;
   point_type   geo_p, geo_q, geo_r;
   geo_res_type geo_res;

   logic accept, out_free, stored, better;

   chgs_geom u_geom (
      .clock (clock),
      .reset (reset),
      .start (geo_start),
      .p     (geo_p),
      .q     (geo_q),
      .r     (geo_r),
      .tol   (tol_ff),
      .res   (geo_res)
   );

   always_ff @(posedge clock) begin
      if (pm_we) begin
         pt_mem[pm_waddr] <= pm_wdata;
      end
      if (pm_re) begin
         pt_rd_ff <= pt_mem[pm_raddr];
      end
   end

   always_ff @(posedge clock) begin
      if (stk_we) begin
         stk_mem[stk_waddr] <= stk_wdata;
      end
      if (stk_re) begin
         stk_rd_ff <= stk_mem[stk_raddr];
      end
   end

   assign csr_ready       = 1'b1;
   assign req_ready       = (state_ff == ST_LOAD);
   assign accept          = req_valid && req_ready;
   assign out_free        = !rsp_valid_ff || rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_hull_x      = rsp_x_ff;
   assign rsp_hull_y      = rsp_y_ff;
   assign rsp_last_vertex = rsp_last_ff;
   assign rsp_no_hull     = rsp_nohull_ff;
   assign rsp_overflowed  = rsp_ov_ff;

   assign stored = count_ff < CNT_W'(MAX_POINTS);
   assign better = (count_ff == '0) || (req_point_y < piv_ff.y) ||
                   ((req_point_y == piv_ff.y) && (req_point_x < piv_ff.x));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         tol_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            tol_ff <= csr_collinear_tolerance;
         end
      end
   end

   always_ff @(posedge clock) begin
      ov_ff         <= ov_in;
      piv_ff        <= piv_in;
      low_ff        <= low_in;
      n_ff          <= n_in;
      m_ff          <= m_in;
      i_ff          <= i_in;
      k_ff          <= k_in;
      d_ff          <= d_in;
      tmp_ff        <= tmp_in;
      prev_ff       <= prev_in;
      sec_ff        <= sec_in;
      top_ff        <= top_in;
      rsp_x_ff      <= rsp_x_in;
      rsp_y_ff      <= rsp_y_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_nohull_ff <= rsp_nohull_in;
      rsp_ov_ff     <= rsp_ov_in;
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      ovf_in        = ovf_ff;
      ov_in         = ov_ff;
      piv_in        = piv_ff;
      low_in        = low_ff;
      n_in          = n_ff;
      m_in          = m_ff;
      i_in          = i_ff;
      k_in          = k_ff;
      d_in          = d_ff;
      tmp_in        = tmp_ff;
      prev_in       = prev_ff;
      sec_in        = sec_ff;
      top_in        = top_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_x_in      = rsp_x_ff;
      rsp_y_in      = rsp_y_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_nohull_in = rsp_nohull_ff;
      rsp_ov_in     = rsp_ov_ff;
      pm_re         = 1'b0;
      pm_raddr      = '0;
      pm_we         = 1'b0;
      pm_waddr      = '0;
      pm_wdata      = tmp_ff;
      stk_re        = 1'b0;
      stk_raddr     = '0;
      stk_we        = 1'b0;
      stk_waddr     = d_ff[IDX_W-1:0];
      stk_wdata     = i_ff[IDX_W-1:0];
      geo_start     = 1'b0;
      geo_p         = piv_ff;
      geo_q         = tmp_ff;
      geo_r         = pt_rd_ff;

      unique case (state_ff)
         ST_LOAD: begin
            if (accept) begin
               if (stored) begin
                  pm_we      = 1'b1;
                  pm_waddr   = count_ff[IDX_W-1:0];
                  pm_wdata.x = req_point_x;
                  pm_wdata.y = req_point_y;
                  count_in   = count_ff + 1'b1;
                  if (better) begin
                     piv_in.x = req_point_x;
                     piv_in.y = req_point_y;
                     low_in   = count_ff[IDX_W-1:0];
                  end
               end else begin
                  ovf_in = 1'b1;
               end
               if (req_last_point) begin
                  n_in     = stored ? count_ff + 1'b1 : count_ff;
                  ov_in    = ovf_ff || !stored;
                  count_in = '0;
                  ovf_in   = 1'b0;
                  state_in = ST_SWAP_RD;
               end
            end
         end

         ST_SWAP_RD: begin
            pm_re    = 1'b1;
            pm_raddr = '0;
            state_in = ST_SWAP_WR;
         end

         ST_SWAP_WR: begin
            pm_we    = 1'b1;
            pm_waddr = low_ff;
            pm_wdata = pt_rd_ff;
            state_in = ST_SWAP_PIV;
         end

         ST_SWAP_PIV: begin
            pm_we    = 1'b1;
            pm_waddr = '0;
            pm_wdata = piv_ff;
            i_in     = CNT_W'(2);
            state_in = ST_SORT_I;
         end

         // insertion sort of entries 1..n-1 around the pivot
         ST_SORT_I: begin
            if (i_ff >= n_ff) begin
               i_in     = CNT_W'(1);
               m_in     = CNT_W'(1);
               state_in = ST_DD_I;
            end else begin
               pm_re    = 1'b1;
               pm_raddr = i_ff[IDX_W-1:0];
               k_in     = i_ff;
               state_in = ST_SORT_TMP;
            end
         end

         ST_SORT_TMP: begin
            tmp_in   = pt_rd_ff;
            state_in = ST_SORT_K;
         end

         ST_SORT_K: begin
            if (k_ff > CNT_W'(1)) begin
               pm_re    = 1'b1;
               pm_raddr = IDX_W'(k_ff - 1'b1);
               state_in = ST_SORT_GO;
            end else begin
               pm_we    = 1'b1;
               pm_waddr = k_ff[IDX_W-1:0];
               pm_wdata = tmp_ff;
               i_in     = i_ff + 1'b1;
               state_in = ST_SORT_I;
            end
         end

         ST_SORT_GO: begin
            prev_in   = pt_rd_ff;
            geo_start = 1'b1;
            state_in  = ST_SORT_WAIT;
         end

         ST_SORT_WAIT: begin
            if (geo_res.valid) begin
               pm_we    = 1'b1;
               pm_waddr = k_ff[IDX_W-1:0];
               if ((geo_res.code == TURN_CCW) ||
                   ((geo_res.code == TURN_COL) && geo_res.nearer)) begin
                  pm_wdata = prev_ff;
                  k_in     = k_ff - 1'b1;
                  state_in = ST_SORT_K;
               end else begin
                  pm_wdata = tmp_ff;
                  i_in     = i_ff + 1'b1;
                  state_in = ST_SORT_I;
               end
            end
         end

         // keep only the farthest point of each collinear run, compacting in place
         ST_DD_I: begin
            if (i_ff >= n_ff) begin
               state_in = ST_CHECK;
            end else begin
               pm_re    = 1'b1;
               pm_raddr = i_ff[IDX_W-1:0];
               state_in = ST_DD_A;
            end
         end

         ST_DD_A: begin
            tmp_in   = pt_rd_ff;
            state_in = ST_DD_J;
         end

         ST_DD_J: begin
            if (i_ff < n_ff - 1'b1) begin
               pm_re    = 1'b1;
               pm_raddr = IDX_W'(i_ff + 1'b1);
               state_in = ST_DD_GO;
            end else begin
               pm_we    = 1'b1;
               pm_waddr = m_ff[IDX_W-1:0];
               pm_wdata = tmp_ff;
               m_in     = m_ff + 1'b1;
               state_in = ST_CHECK;
            end
         end

         ST_DD_GO: begin
            prev_in   = pt_rd_ff;
            geo_start = 1'b1;
            state_in  = ST_DD_WAIT;
         end

         ST_DD_WAIT: begin
            if (geo_res.valid) begin
               if (geo_res.code != TURN_COL) begin
                  pm_we    = 1'b1;
                  pm_waddr = m_ff[IDX_W-1:0];
                  pm_wdata = tmp_ff;
                  m_in     = m_ff + 1'b1;
               end
               i_in     = i_ff + 1'b1;
               tmp_in   = prev_ff;
               state_in = ST_DD_J;
            end
         end

         ST_CHECK: begin
            if (m_ff < CNT_W'(3)) begin
               if (out_free) begin
                  rsp_valid_in  = 1'b1;
                  rsp_x_in      = '0;
                  rsp_y_in      = '0;
                  rsp_last_in   = 1'b1;
                  rsp_nohull_in = 1'b1;
                  rsp_ov_in     = ov_ff;
                  state_in      = ST_LOAD;
               end
            end else begin
               state_in = ST_SC_INIT0;
            end
         end

         // stack scan; sec/top mirror the two top stack entries' points
         ST_SC_INIT0: begin
            stk_we    = 1'b1;
            stk_waddr = '0;
            stk_wdata = '0;
            pm_re     = 1'b1;
            pm_raddr  = IDX_W'(1);
            state_in  = ST_SC_INIT1;
         end

         ST_SC_INIT1: begin
            stk_we    = 1'b1;
            stk_waddr = IDX_W'(1);
            stk_wdata = IDX_W'(1);
            sec_in    = pt_rd_ff;
            pm_re     = 1'b1;
            pm_raddr  = IDX_W'(2);
            state_in  = ST_SC_INIT2;
         end

         ST_SC_INIT2: begin
            stk_we    = 1'b1;
            stk_waddr = IDX_W'(2);
            stk_wdata = IDX_W'(2);
            top_in    = pt_rd_ff;
            d_in      = CNT_W'(3);
            i_in      = CNT_W'(3);
            state_in  = ST_SC_I;
         end

         ST_SC_I: begin
            if (i_ff >= m_ff) begin
               state_in = ST_EM_RD;
            end else begin
               pm_re    = 1'b1;
               pm_raddr = i_ff[IDX_W-1:0];
               state_in = ST_SC_C;
            end
         end

         ST_SC_C: begin
            tmp_in   = pt_rd_ff;
            state_in = ST_SC_TEST;
         end

         ST_SC_TEST: begin
            if (d_ff > CNT_W'(1)) begin
               geo_start = 1'b1;
               geo_p     = sec_ff;
               geo_q     = top_ff;
               geo_r     = tmp_ff;
               state_in  = ST_SC_WAIT;
            end else begin
               stk_we   = 1'b1;
               sec_in   = top_ff;
               top_in   = tmp_ff;
               d_in     = d_ff + 1'b1;
               i_in     = i_ff + 1'b1;
               state_in = ST_SC_I;
            end
         end

         ST_SC_WAIT: begin
            if (geo_res.valid) begin
               if (geo_res.code != TURN_CCW) begin
                  top_in = sec_ff;
                  d_in   = d_ff - 1'b1;
                  if (d_ff > CNT_W'(2)) begin
                     stk_re    = 1'b1;
                     stk_raddr = IDX_W'(d_ff - CNT_W'(3));
                     state_in  = ST_SC_POP1;
                  end else begin
                     state_in = ST_SC_TEST;
                  end
               end else begin
                  stk_we   = 1'b1;
                  sec_in   = top_ff;
                  top_in   = tmp_ff;
                  d_in     = d_ff + 1'b1;
                  i_in     = i_ff + 1'b1;
                  state_in = ST_SC_I;
               end
            end
         end

         ST_SC_POP1: begin
            pm_re    = 1'b1;
            pm_raddr = stk_rd_ff;
            state_in = ST_SC_POP2;
         end

         ST_SC_POP2: begin
            sec_in   = pt_rd_ff;
            state_in = ST_SC_TEST;
         end

         // emit top of stack first
         ST_EM_RD: begin
            stk_re    = 1'b1;
            stk_raddr = IDX_W'(d_ff - 1'b1);
            state_in  = ST_EM_PT;
         end

         ST_EM_PT: begin
            pm_re    = 1'b1;
            pm_raddr = stk_rd_ff;
            state_in = ST_EM_OUT;
         end

         ST_EM_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_x_in      = pt_rd_ff.x;
               rsp_y_in      = pt_rd_ff.y;
               rsp_last_in   = (d_ff == CNT_W'(1));
               rsp_nohull_in = 1'b0;
               rsp_ov_in     = ov_ff;
               d_in          = d_ff - 1'b1;
               state_in      = (d_ff == CNT_W'(1)) ? ST_LOAD : ST_EM_RD;
            end
         end

         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule
